// ===== hdl/assert_macros.svh =====
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, masked while reset is held
`define ASSERT_CLK(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("assertion failed");

// clocked property, checked through reset as well
`define ASSERT_CLK_RST(label, prop) \
    label: assert property (@(posedge i_clk) prop) \
        else $error("assertion failed");

`endif

// ===== hdl/mscl_pkg.sv =====
// types, constants and helper functions of the midpoint line clipper
`timescale 1ns / 1ps
`default_nettype none

package mscl_pkg;

    localparam int COORD_BITS = 12;
    localparam int DATA_W     = 32;
    localparam int ADDR_W     = 4;
    localparam int ITER_LIMIT = 2 * COORD_BITS + 8;
    localparam int ITER_W     = $clog2(ITER_LIMIT + 1);

    localparam int WIN_LEFT_RST   = 0;
    localparam int WIN_BOTTOM_RST = 0;
    localparam int WIN_RIGHT_RST  = 639;
    localparam int WIN_TOP_RST    = 479;

    localparam logic [3:0] CODE_LEFT   = 4'b1000;
    localparam logic [3:0] CODE_RIGHT  = 4'b0100;
    localparam logic [3:0] CODE_BOTTOM = 4'b0010;
    localparam logic [3:0] CODE_TOP    = 4'b0001;

    typedef logic signed [COORD_BITS-1:0] t_coord;

    typedef enum logic [1:0] {
        REG_LEFT   = 2'd0,
        REG_BOTTOM = 2'd1,
        REG_RIGHT  = 2'd2,
        REG_TOP    = 2'd3
    } t_reg_idx;

    typedef struct packed {
        t_coord start_x;
        t_coord start_y;
        t_coord end_x;
        t_coord end_y;
    } t_in_item;

    typedef struct packed {
        logic   visible;
        t_coord clip_start_x;
        t_coord clip_start_y;
        t_coord clip_end_x;
        t_coord clip_end_y;
    } t_out_item;

    typedef struct packed {
        t_coord left;
        t_coord bottom;
        t_coord right;
        t_coord top;
    } t_window;

    typedef enum logic [1:0] {
        S_IDLE       = 2'd0,
        S_SEEK_START = 2'd1,
        S_SEEK_END   = 2'd2
    } t_state;

    typedef struct packed {
        logic load;
        logic step;
        logic next_phase;
        logic pick_a;
        logic write_out;
        logic visible;
    } t_dp_cmd;

    typedef struct packed {
        logic a_in;
        logic b_in;
        logic close;
        logic share;
    } t_dp_status;

    function automatic logic [3:0] region(input t_coord x, input t_coord y,
                                          input t_window w);
        logic [3:0] c;
        c = 4'b0000;
        if (x < w.left)   c = c | CODE_LEFT;
        if (x > w.right)  c = c | CODE_RIGHT;
        if (y < w.bottom) c = c | CODE_BOTTOM;
        if (y > w.top)    c = c | CODE_TOP;
        return c;
    endfunction

    // true when two coordinates differ by at most one
    function automatic logic near(input t_coord a, input t_coord b);
        logic signed [COORD_BITS:0] d;
        d = {a[COORD_BITS-1], a} - {b[COORD_BITS-1], b};
        return (d == '0) || (d == (COORD_BITS+1)'(1)) || (d == '1);
    endfunction

endpackage

`default_nettype wire

// ===== hdl/mscl_cfg.sv =====
// window registers behind the apb-style configuration port
`timescale 1ns / 1ps
`default_nettype none

module mscl_cfg (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [mscl_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [mscl_pkg::DATA_W-1:0]  pwdata,
    output logic      [mscl_pkg::DATA_W-1:0]  prdata,
    output logic                              pready,
    output mscl_pkg::t_window                 o_window
);

    localparam int CB = mscl_pkg::COORD_BITS;

    mscl_pkg::t_window  r_win;
    mscl_pkg::t_reg_idx idx;
    mscl_pkg::t_coord   rd_val;
    logic               wr_en;

    assign idx    = mscl_pkg::t_reg_idx'(paddr[3:2]);
    assign wr_en  = psel && penable && pwrite && pready;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win.left   <= mscl_pkg::t_coord'(mscl_pkg::WIN_LEFT_RST);
            r_win.bottom <= mscl_pkg::t_coord'(mscl_pkg::WIN_BOTTOM_RST);
            r_win.right  <= mscl_pkg::t_coord'(mscl_pkg::WIN_RIGHT_RST);
            r_win.top    <= mscl_pkg::t_coord'(mscl_pkg::WIN_TOP_RST);
        end else if (wr_en) begin
            unique case (idx)
                mscl_pkg::REG_LEFT:   r_win.left   <= pwdata[CB-1:0];
                mscl_pkg::REG_BOTTOM: r_win.bottom <= pwdata[CB-1:0];
                mscl_pkg::REG_RIGHT:  r_win.right  <= pwdata[CB-1:0];
                mscl_pkg::REG_TOP:    r_win.top    <= pwdata[CB-1:0];
                default:              r_win        <= r_win;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            mscl_pkg::REG_LEFT:   rd_val = r_win.left;
            mscl_pkg::REG_BOTTOM: rd_val = r_win.bottom;
            mscl_pkg::REG_RIGHT:  rd_val = r_win.right;
            mscl_pkg::REG_TOP:    rd_val = r_win.top;
            default:              rd_val = r_win.left;
        endcase
    end

    assign prdata   = {{(mscl_pkg::DATA_W-CB){rd_val[CB-1]}}, rd_val};
    assign o_window = r_win;

endmodule

`default_nettype wire

// ===== hdl/mscl_dp.sv =====
// datapath: endpoint registers, midpoint bisection step and result register
`timescale 1ns / 1ps
`default_nettype none

module mscl_dp (
    input  wire logic                  i_clk,
    input  mscl_pkg::t_in_item         i_in_data,
    input  mscl_pkg::t_window          i_window,
    input  mscl_pkg::t_dp_cmd          i_cmd,
    output mscl_pkg::t_dp_status       o_status,
    output mscl_pkg::t_out_item        o_out_data
);

    localparam int CB = mscl_pkg::COORD_BITS;

    mscl_pkg::t_coord r_ax, r_ay, r_bx, r_by;
    mscl_pkg::t_coord r_ex, r_ey, r_sx, r_sy;
    mscl_pkg::t_out_item r_out;

    logic signed [CB:0] sum_x, sum_y;
    mscl_pkg::t_coord   mx, my, fx, fy;
    logic [3:0]         ca, cb, cm;

    // floor of the halved sum is the upper bits of the widened sum
    assign sum_x = {r_ax[CB-1], r_ax} + {r_bx[CB-1], r_bx};
    assign sum_y = {r_ay[CB-1], r_ay} + {r_by[CB-1], r_by};
    assign mx    = sum_x[CB:1];
    assign my    = sum_y[CB:1];

    assign ca = mscl_pkg::region(r_ax, r_ay, i_window);
    assign cb = mscl_pkg::region(r_bx, r_by, i_window);
    assign cm = mscl_pkg::region(mx, my, i_window);

    always_comb begin
        o_status.a_in  = (ca == 4'b0000);
        o_status.b_in  = (cb == 4'b0000);
        o_status.share = ((ca & cb) != 4'b0000);
        o_status.close = mscl_pkg::near(r_ax, r_bx) && mscl_pkg::near(r_ay, r_by);
    end

    assign fx = i_cmd.pick_a ? r_ax : r_bx;
    assign fy = i_cmd.pick_a ? r_ay : r_by;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_ax <= i_in_data.start_x;
            r_ay <= i_in_data.start_y;
            r_bx <= i_in_data.end_x;
            r_by <= i_in_data.end_y;
            r_ex <= i_in_data.end_x;
            r_ey <= i_in_data.end_y;
        end else if (i_cmd.step) begin
            // drop the half that lies wholly beyond a window edge
            if ((ca & cm) != 4'b0000) begin
                r_ax <= mx;
                r_ay <= my;
            end else begin
                r_bx <= mx;
                r_by <= my;
            end
        end else if (i_cmd.next_phase) begin
            r_sx <= fx;
            r_sy <= fy;
            r_ax <= r_ex;
            r_ay <= r_ey;
            r_bx <= fx;
            r_by <= fy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.write_out) begin
            if (i_cmd.visible) begin
                r_out.visible      <= 1'b1;
                r_out.clip_start_x <= r_sx;
                r_out.clip_start_y <= r_sy;
                r_out.clip_end_x   <= fx;
                r_out.clip_end_y   <= fy;
            end else begin
                r_out <= '0;
            end
        end
    end

    assign o_out_data = r_out;

endmodule

`default_nettype wire

// ===== hdl/mscl_ctrl.sv =====
// controller: sequences the two endpoint searches and owns both handshakes
`timescale 1ns / 1ps
`default_nettype none

module mscl_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    output logic                  o_out_valid,
    input  wire logic             i_out_ready,
    input  mscl_pkg::t_dp_status  i_status,
    output mscl_pkg::t_dp_cmd     o_cmd
);

    localparam int IW = mscl_pkg::ITER_W;

    mscl_pkg::t_state r_state, n_state;
    logic [IW-1:0]    r_iter, n_iter;
    logic             r_out_valid, n_out_valid;

    logic first, last, out_free;
    logic d_fail, d_found_a, d_found_b, d_step, found;

    assign first    = (r_iter == '0);
    assign last     = (r_iter == IW'(mscl_pkg::ITER_LIMIT));
    assign out_free = !r_out_valid || i_out_ready;

    // one decision per search cycle
    always_comb begin
        d_fail    = 1'b0;
        d_found_a = 1'b0;
        d_found_b = 1'b0;
        d_step    = 1'b0;
        if (first && i_status.share) begin
            d_fail = 1'b1;
        end else if (first && i_status.a_in) begin
            d_found_a = 1'b1;
        end else if (i_status.close || last) begin
            if (i_status.b_in) begin
                d_found_b = 1'b1;
            end else begin
                d_fail = 1'b1;
            end
        end else if (i_status.share) begin
            d_fail = 1'b1;
        end else begin
            d_step = 1'b1;
        end
    end

    assign found = d_found_a || d_found_b;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            mscl_pkg::S_IDLE: begin
                if (i_in_valid) n_state = mscl_pkg::S_SEEK_START;
            end
            mscl_pkg::S_SEEK_START: begin
                if (found) begin
                    n_state = mscl_pkg::S_SEEK_END;
                end else if (d_fail && out_free) begin
                    n_state = mscl_pkg::S_IDLE;
                end
            end
            mscl_pkg::S_SEEK_END: begin
                if ((found || d_fail) && out_free) n_state = mscl_pkg::S_IDLE;
            end
            default: n_state = mscl_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready       = 1'b0;
        o_cmd            = '0;
        o_cmd.pick_a     = d_found_a;
        unique case (r_state)
            mscl_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            mscl_pkg::S_SEEK_START: begin
                o_cmd.step       = d_step;
                o_cmd.next_phase = found;
                o_cmd.write_out  = d_fail && out_free;
            end
            mscl_pkg::S_SEEK_END: begin
                o_cmd.step      = d_step;
                o_cmd.write_out = (found || d_fail) && out_free;
                o_cmd.visible   = found;
            end
            default: o_cmd = '0;
        endcase
    end

    always_comb begin
        n_iter = r_iter;
        if (o_cmd.load || o_cmd.next_phase) begin
            n_iter = '0;
        end else if (o_cmd.step) begin
            n_iter = r_iter + IW'(1);
        end
        n_out_valid = r_out_valid;
        if (o_cmd.write_out) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= mscl_pkg::S_IDLE;
            r_iter      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_iter      <= n_iter;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

// ===== hdl/midpoint_subdivision_line_clipper.sv =====
// top level of the midpoint subdivision line clipper
// each item runs up to two endpoint searches, start then end; a search halves the segment
//   step by step and ends on a decision that finds the endpoint or rejects the segment
// a new item is taken only once the last result is written to the output register,
//   and both searches use the single shared bisection step in the datapath
// a finished result waits in the output register while the next item is taken
// reset: synchronous, active low; window returns to 0,0..639,479, no result pending
`timescale 1ns / 1ps
`default_nettype none

module midpoint_subdivision_line_clipper (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_in_valid,
    output logic                              o_in_ready,
    input  mscl_pkg::t_in_item                i_in_data,
    output logic                              o_out_valid,
    input  wire logic                         i_out_ready,
    output mscl_pkg::t_out_item               o_out_data,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [mscl_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [mscl_pkg::DATA_W-1:0]  pwdata,
    output logic      [mscl_pkg::DATA_W-1:0]  prdata,
    output logic                              pready
);

    mscl_pkg::t_window    window;
    mscl_pkg::t_dp_cmd    cmd;
    mscl_pkg::t_dp_status status;

    mscl_cfg u_cfg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .o_window (window)
    );

    mscl_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    mscl_dp u_dp (
        .i_clk      (i_clk),
        .i_in_data  (i_in_data),
        .i_window   (window),
        .i_cmd      (cmd),
        .o_status   (status),
        .o_out_data (o_out_data)
    );

endmodule

`default_nettype wire

// ===== hdl/mscl_checker.sv =====
// port-level checks of the line clipper, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module mscl_checker (
    input wire logic           i_clk,
    input wire logic           i_rst_n,
    input wire logic           i_in_valid,
    input wire logic           o_in_ready,
    input wire logic           o_out_valid,
    input wire logic           i_out_ready,
    input mscl_pkg::t_out_item o_out_data
);

    // the four endpoint coordinates sit below the visible bit
    localparam int PTS_W = 4 * mscl_pkg::COORD_BITS;

    // a stalled result holds
    `ASSERT_CLK(a_out_hold, o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
    // rejected segments carry zero endpoints
    `ASSERT_CLK(a_reject_zero, o_out_valid && !o_out_data.visible |-> o_out_data[PTS_W-1:0] == '0)
    // one item at a time: input closes right after an accept
    `ASSERT_CLK(a_one_item, i_in_valid && o_in_ready |=> !o_in_ready)
    // no result pending after reset
    `ASSERT_CLK_RST(a_reset_empty, !i_rst_n |=> !o_out_valid)

endmodule

bind midpoint_subdivision_line_clipper mscl_checker u_mscl_checker (.*);

`default_nettype wire
